[rtl/ntlt_pkg.sv]
// ----------------------------------------------------------------------------
// ntlt_pkg
// Constants and helpers for the NTP to local time pipeline: stage map,
// reciprocal multipliers for the calendar breakdown, month start offsets.
// ----------------------------------------------------------------------------
package ntlt_pkg;

    localparam int NUM_STAGES = 11;
    localparam int CIV_FIRST  = 3;
    localparam int CIV_LAST   = 9;

    localparam logic [31:0] NTP_UNIX_DELTA = 32'd2208988800;
    localparam logic [31:0] SUMMER_SECONDS = 32'd3600;
    localparam logic [31:0] HOUR_SECONDS   = 32'd3600;
    localparam logic [32:0] DAY_SECONDS    = 33'd86400;
    localparam logic [16:0] ZONE_RESET     = 17'd3600;

    // x / 675 for x < 2^25: (x * RECIP_675) >> 35, exact
    localparam logic [25:0] RECIP_675  = 26'd50903317;
    // x / 1460 for x < 146097: >> 28
    localparam logic [17:0] RECIP_1460 = 18'd183860;
    // x / 365 for x < 146097: >> 27
    localparam logic [18:0] RECIP_365  = 19'd367720;
    // x / 153 for x < 1828: >> 20
    localparam logic [12:0] RECIP_153  = 13'd6854;

    // days from 1600-03-01 to 1970-01-01
    localparam logic [17:0] ERA_DAY_OFS = 18'd135080;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [17:0] CENT_DAYS   = 18'd36524;

    localparam logic [4:0] MARCH_DAYS  = 5'd31;
    localparam logic [3:0] BEGIN_MONTH = 4'd3;
    localparam logic [3:0] END_MONTH   = 4'd10;

    // first day of year-of-March month index, counted from March 1
    function automatic logic [8:0] f_month_start(input logic [3:0] mp);
        logic [8:0] ofs;
        case (mp)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

    // mod 7 by octal digit folding (8 = 1 mod 7)
    function automatic logic [2:0] f_mod7(input logic [12:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]) + 5'(v[12]);
        s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

[rtl/ntlt_civil.sv]
// ----------------------------------------------------------------------------
// ntlt_civil
// Pipelined day count (from 1970-01-01) to Gregorian year, month and day.
// Seven register stages, one per enable bit.
// ----------------------------------------------------------------------------
module ntlt_civil
    import ntlt_pkg::*;
(
    input  logic                        i_clk,
    input  logic [CIV_LAST:CIV_FIRST]   i_en,
    input  logic [15:0]                 i_days,
    output logic [11:0]                 o_year,
    output logic [3:0]                  o_month,
    output logic [4:0]                  o_day
);

    // stage 3: day of 400-year era
    logic [17:0] s3_z;
    logic        s3_era;
    logic [17:0] r_doe3;
    logic        r_era3;

    assign s3_z   = 18'(i_days) + ERA_DAY_OFS;
    assign s3_era = (s3_z >= ERA_DAYS);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_era3 <= s3_era;
            r_doe3 <= s3_era ? (s3_z - ERA_DAYS) : s3_z;
        end
    end

    // stage 4: doe/1460, doe/36524, doe/146096
    logic [35:0] s4_prod;
    logic [6:0]  r_a4;
    logic [2:0]  r_b4;
    logic        r_c4;
    logic [17:0] r_doe4;
    logic        r_era4;

    assign s4_prod = 36'(r_doe3) * 36'(RECIP_1460);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_a4   <= s4_prod[34:28];
            r_b4   <= 3'(r_doe3 >= CENT_DAYS) + 3'(r_doe3 >= 18'd73048)
                    + 3'(r_doe3 >= 18'd109572) + 3'(r_doe3 >= 18'd146096);
            r_c4   <= (r_doe3 == 18'd146096);
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
        end
    end

    // stage 5: leap-corrected day count
    logic [17:0] r_num5;
    logic [17:0] r_doe5;
    logic        r_era5;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_num5 <= r_doe4 - 18'(r_a4) + 18'(r_b4) - 18'(r_c4);
            r_doe5 <= r_doe4;
            r_era5 <= r_era4;
        end
    end

    // stage 6: year of era
    logic [36:0] s6_prod;
    logic [8:0]  r_yoe6;
    logic [17:0] r_doe6;
    logic        r_era6;

    assign s6_prod = 37'(r_num5) * 37'(RECIP_365);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_yoe6 <= s6_prod[35:27];
            r_doe6 <= r_doe5;
            r_era6 <= r_era5;
        end
    end

    // stage 7: day of March-based year
    logic [1:0]  s7_cent;
    logic [17:0] s7_sub;
    logic [8:0]  r_doy7;
    logic [11:0] r_yb7;

    always_comb begin
        if (r_yoe6 >= 9'd300) begin
            s7_cent = 2'd3;
        end else if (r_yoe6 >= 9'd200) begin
            s7_cent = 2'd2;
        end else if (r_yoe6 >= 9'd100) begin
            s7_cent = 2'd1;
        end else begin
            s7_cent = 2'd0;
        end
    end

    assign s7_sub = 18'(r_yoe6) * 18'd365 + 18'(r_yoe6[8:2]) - 18'(s7_cent);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_doy7 <= 9'(r_doe6 - s7_sub);
            r_yb7  <= 12'd1600 + (r_era6 ? 12'd400 : 12'd0) + 12'(r_yoe6);
        end
    end

    // stage 8: month index from March
    logic [10:0] s8_x;
    logic [23:0] s8_prod;
    logic [3:0]  r_mp8;
    logic [8:0]  r_doy8;
    logic [11:0] r_yb8;

    assign s8_x    = 11'(r_doy7) * 11'd5 + 11'd2;
    assign s8_prod = 24'(s8_x) * 24'(RECIP_153);

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_mp8  <= s8_prod[23:20];
            r_doy8 <= r_doy7;
            r_yb8  <= r_yb7;
        end
    end

    // stage 9: calendar month, day, year
    logic        s9_wrap;
    logic [11:0] r_year9;
    logic [3:0]  r_month9;
    logic [4:0]  r_day9;

    assign s9_wrap = (r_mp8 >= 4'd10);

    always_ff @(posedge i_clk) begin
        if (i_en[9]) begin
            r_day9   <= 5'(r_doy8 - f_month_start(r_mp8) + 9'd1);
            r_month9 <= s9_wrap ? (r_mp8 - 4'd9) : (r_mp8 + 4'd3);
            r_year9  <= r_yb8 + 12'(s9_wrap);
        end
    end

    assign o_year  = r_year9;
    assign o_month = r_month9;
    assign o_day   = r_day9;

endmodule

[rtl/ntp_to_local_time_with_dst.sv]
// ----------------------------------------------------------------------------
// ntp_to_local_time_with_dst
// NTP seconds to local Unix seconds with zone offset and European summer
// time (last Sunday of March to last Sunday of October, 01:00 UTC).
// ----------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  in      | in  | i_in_valid / o_in_ready   | i_ntp_seconds[31:0]
//  out     | out | o_out_valid / i_out_ready | o_local_seconds[31:0],
//          |     |                           | o_summer_time_active
//  cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_data[16:0] (zone offset)
//
//  11-stage pipeline, one beat per cycle while the output is not stalled.
//  Per-stage valid bits; a stage loads when empty or when the next one moves,
//  so bubbles close up under an output stall and no beat is lost or repeated.
//  Synchronous active-low reset clears the valid bits and sets the zone
//  offset to 3600. Config writes are always accepted.
// ----------------------------------------------------------------------------
module ntp_to_local_time_with_dst
    import ntlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_ntp_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_local_seconds,
    output logic        o_summer_time_active,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    logic [NUM_STAGES:1] en;
    logic [NUM_STAGES:1] r_v;
    logic [16:0]         r_zone;

    always_comb begin
        en[NUM_STAGES] = !r_v[NUM_STAGES] || i_out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_zone <= i_cfg_data;
        end
    end

    // UTC seconds travel with the beat through stage 10
    logic [31:0] r_unix [1:NUM_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_unix[1] <= i_ntp_seconds - NTP_UNIX_DELTA;
        end
        for (int k = 2; k <= NUM_STAGES - 1; k++) begin
            if (en[k]) begin
                r_unix[k] <= r_unix[k - 1];
            end
        end
    end

    // stage 2: days = unix / 86400 = (unix >> 7) / 675
    logic [50:0] s2_prod;
    logic [15:0] r_days;

    assign s2_prod = 51'(r_unix[1][31:7]) * 51'(RECIP_675);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_days <= s2_prod[50:35];
        end
    end

    // stage 3/4: second of day >= 01:00
    logic [32:0] s3_prod;
    logic [31:0] r_dsec;
    logic        r_hge [4:NUM_STAGES-2];

    assign s3_prod = 33'(r_days) * DAY_SECONDS;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_dsec <= s3_prod[31:0];
        end
        if (en[4]) begin
            r_hge[4] <= ((r_unix[3] - r_dsec) >= HOUR_SECONDS);
        end
        for (int k = 5; k <= NUM_STAGES - 2; k++) begin
            if (en[k]) begin
                r_hge[k] <= r_hge[k - 1];
            end
        end
    end

    // stages 3..9: calendar breakdown
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;

    ntlt_civil u_civil (
        .i_clk   (i_clk),
        .i_en    (en[CIV_LAST:CIV_FIRST]),
        .i_days  (r_days),
        .o_year  (cal_year),
        .o_month (cal_month),
        .o_day   (cal_day)
    );

    // stage 10: summer time rule
    logic [13:0] s10_y5;
    logic [11:0] s10_v;
    logic [4:0]  s10_bday;
    logic [4:0]  s10_eday;
    logic        s10_summer;
    logic        r_summer10;

    assign s10_y5   = 14'(cal_year) * 14'd5;
    assign s10_v    = s10_y5[13:2];
    assign s10_bday = MARCH_DAYS - 5'(f_mod7(13'(s10_v) + 13'd4));
    assign s10_eday = MARCH_DAYS - 5'(f_mod7(13'(s10_v) + 13'd1));

    always_comb begin
        if (cal_month > BEGIN_MONTH && cal_month < END_MONTH) begin
            s10_summer = 1'b1;
        end else if (cal_month == BEGIN_MONTH) begin
            s10_summer = (cal_day > s10_bday)
                      || (cal_day == s10_bday && r_hge[9]);
        end else if (cal_month == END_MONTH) begin
            s10_summer = (cal_day < s10_eday)
                      || (cal_day == s10_eday && !r_hge[9]);
        end else begin
            s10_summer = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_summer10 <= s10_summer;
        end
    end

    // stage 11: output register
    logic [31:0] r_local;
    logic        r_summer11;

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_local    <= r_unix[10] + (r_summer10 ? SUMMER_SECONDS : 32'd0)
                        + {{15{r_zone[16]}}, r_zone};
            r_summer11 <= r_summer10;
        end
    end

    assign o_in_ready           = en[1];
    assign o_out_valid          = r_v[NUM_STAGES];
    assign o_local_seconds      = r_local;
    assign o_summer_time_active = r_summer11;
    assign o_cfg_ready          = 1'b1;

endmodule

[rtl/ntlt_chk.sv]
// ----------------------------------------------------------------------------
// ntlt_chk
// Port-level checks for ntp_to_local_time_with_dst, bound to the top level.
// ----------------------------------------------------------------------------
module ntlt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [31:0] i_ntp_seconds,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_local_seconds,
    input logic        o_summer_time_active,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [16:0] i_cfg_data
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_local_seconds) && $stable(o_summer_time_active))
        else $error("output beat changed under stall");

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // an empty or draining output slot never blocks the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled with output free");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config beat refused");

endmodule

bind ntp_to_local_time_with_dst ntlt_chk u_ntlt_chk (.*);
